// ===== design/slfs_pkg.sv =====
// ----------------------------------------------------------------------------
// slfs_pkg
// Shared types, codes and helpers of the skip list forward search block.
// ----------------------------------------------------------------------------
package slfs_pkg;

    localparam int unsigned DEF_STORE_DEPTH = 32;

    localparam int unsigned WORD_W = 32;

    // item modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PUSH  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic signed [WORD_W-1:0] SKIP_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SKIP_INIT = -32'sd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRY
    } t_state;

    // one skip entry as held in the store
    typedef struct packed {
        logic [WORD_W-1:0] doc_delta;
        logic [WORD_W-1:0] ttf_delta;
        logic [WORD_W-1:0] offset_delta;
    } t_entry;

    typedef struct packed {
        logic                     found;
        logic [WORD_W-1:0]        doc_id;
        logic [WORD_W-1:0]        prev_doc_id;
        logic [WORD_W-1:0]        prev_offset;
        logic [WORD_W-1:0]        offset_span;
        logic [WORD_W-1:0]        prev_total_freq;
        logic signed [WORD_W-1:0] skipped_count;
    } t_result;

    // saturating step of the skip counter
    function automatic logic signed [WORD_W-1:0] bump_skip(
        input logic signed [WORD_W-1:0] cnt
    );
        logic signed [WORD_W-1:0] res;
        res = cnt;
        if (cnt != SKIP_MAX) begin
            res = cnt + 32'sd1;
        end
        return res;
    endfunction

endpackage

// ===== design/slfs_store.sv =====
// ----------------------------------------------------------------------------
// slfs_store
// Skip entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slfs_store #(
    parameter int unsigned DEPTH  = slfs_pkg::DEF_STORE_DEPTH,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  slfs_pkg::t_entry    i_wr_data,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output slfs_pkg::t_entry    o_rd_data
);

    slfs_pkg::t_entry r_mem [DEPTH];
    slfs_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/skip_list_forward_search_top.sv =====
// ----------------------------------------------------------------------------
// skip_list_forward_search_top
// Forward-only skip-to search over a FIFO of delta-coded skip entries.
// ----------------------------------------------------------------------------
// Usage: drive i_mode and the payload ports and raise start; the word is
// taken at a rising edge with start high and busy low. Mode clear resets the
// list state, mode push appends one entry (dropped when the store is full),
// mode query walks entries from the head, summing their deltas until the
// docid sum reaches i_query_doc. Clear and push give no result. A query
// keeps busy high through ST_WALK (and ST_DRY when the store runs dry)
// and shows its result on the o_ ports, marked by o_valid, for exactly
// one cycle right after busy falls; an empty store gives the not-found
// result in the cycle after the accept. The walk reads one entry per cycle
// from the single read port of the store memory. The receiver cannot stall:
// the result register is overwritten by the next query. A synchronous reset
// (i_rst_n low) empties the list and zeroes the sums; the store contents
// are left undefined and are never read before written.
// ----------------------------------------------------------------------------
module skip_list_forward_search_top #(
    parameter int unsigned STORE_DEPTH = slfs_pkg::DEF_STORE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [31:0]         i_doc_delta,
    input  logic [31:0]         i_ttf_delta,
    input  logic [31:0]         i_offset_delta,
    input  logic [31:0]         i_query_doc,
    output logic                o_valid,
    output logic                o_found,
    output logic [31:0]         o_doc_id,
    output logic [31:0]         o_prev_doc_id,
    output logic [31:0]         o_prev_offset,
    output logic [31:0]         o_offset_span,
    output logic [31:0]         o_prev_total_freq,
    output logic signed [31:0]  o_skipped_count
);

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int unsigned SUM_W  = ADDR_W + 1;

    slfs_pkg::t_state           r_state, n_state;
    logic [ADDR_W-1:0]          r_rd_idx, n_rd_idx;
    logic [FILL_W-1:0]          r_fill, n_fill;
    logic [31:0]                r_sum_doc, n_sum_doc;
    logic [31:0]                r_sum_off, n_sum_off;
    logic [31:0]                r_sum_ttf, n_sum_ttf;
    logic signed [31:0]         r_skip, n_skip;
    logic [31:0]                r_query, n_query;
    logic                       r_valid, n_valid;
    slfs_pkg::t_result          r_out, n_out;

    logic                       accept;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [SUM_W-1:0]           wr_sum;
    slfs_pkg::t_entry           wr_data;
    logic                       rd_en;
    slfs_pkg::t_entry           rd_data;
    logic [ADDR_W-1:0]          rd_idx_inc;
    logic [31:0]                doc_next;

    assign accept = start && (r_state == slfs_pkg::ST_IDLE);
    assign busy   = (r_state != slfs_pkg::ST_IDLE);

    // tail slot = head + occupancy, wrapped once
    assign wr_sum  = SUM_W'(r_rd_idx) + SUM_W'(r_fill);
    assign wr_addr = (wr_sum >= SUM_W'(STORE_DEPTH)) ?
                     ADDR_W'(wr_sum - SUM_W'(STORE_DEPTH)) : ADDR_W'(wr_sum);
    assign wr_en   = accept && (i_mode == slfs_pkg::MODE_PUSH) &&
                     (r_fill < FILL_W'(STORE_DEPTH));
    assign wr_data = '{doc_delta: i_doc_delta, ttf_delta: i_ttf_delta,
                       offset_delta: i_offset_delta};

    assign rd_idx_inc = (r_rd_idx == ADDR_W'(STORE_DEPTH - 1)) ?
                        '0 : r_rd_idx + ADDR_W'(1);
    assign doc_next   = r_sum_doc + rd_data.doc_delta;

    slfs_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_fill    = r_fill;
        n_sum_doc = r_sum_doc;
        n_sum_off = r_sum_off;
        n_sum_ttf = r_sum_ttf;
        n_skip    = r_skip;
        n_query   = r_query;
        n_valid   = 1'b0;
        n_out     = r_out;
        rd_en     = 1'b0;

        unique case (r_state)
            slfs_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        slfs_pkg::MODE_CLEAR: begin
                            n_rd_idx  = '0;
                            n_fill    = '0;
                            n_sum_doc = '0;
                            n_sum_off = '0;
                            n_sum_ttf = '0;
                            n_skip    = slfs_pkg::SKIP_INIT;
                        end
                        slfs_pkg::MODE_PUSH: begin
                            if (wr_en) begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        slfs_pkg::MODE_QUERY: begin
                            n_query = i_query_doc;
                            n_skip  = slfs_pkg::bump_skip(r_skip);
                            if (r_fill == '0) begin
                                // empty list: report not found at once
                                n_valid = 1'b1;
                                n_out   = '0;
                                n_out.skipped_count = slfs_pkg::bump_skip(r_skip);
                            end else begin
                                rd_en    = 1'b1;
                                n_rd_idx = rd_idx_inc;
                                n_fill   = r_fill - FILL_W'(1);
                                n_state  = slfs_pkg::ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slfs_pkg::ST_WALK: begin
                // entry popped last cycle is on rd_data
                n_sum_doc = doc_next;
                n_sum_off = r_sum_off + rd_data.offset_delta;
                n_sum_ttf = r_sum_ttf + rd_data.ttf_delta;
                if (doc_next >= r_query) begin
                    n_valid                   = 1'b1;
                    n_out.found               = 1'b1;
                    n_out.doc_id              = doc_next;
                    n_out.prev_doc_id         = r_sum_doc;
                    n_out.prev_offset         = r_sum_off;
                    n_out.offset_span         = rd_data.offset_delta;
                    n_out.prev_total_freq     = r_sum_ttf;
                    n_out.skipped_count       = r_skip;
                    n_state                   = slfs_pkg::ST_IDLE;
                end else if (r_fill == '0) begin
                    n_state = slfs_pkg::ST_DRY;
                end else begin
                    n_skip   = slfs_pkg::bump_skip(r_skip);
                    rd_en    = 1'b1;
                    n_rd_idx = rd_idx_inc;
                    n_fill   = r_fill - FILL_W'(1);
                end
            end
            slfs_pkg::ST_DRY: begin
                // failing step still counts
                n_skip              = slfs_pkg::bump_skip(r_skip);
                n_valid             = 1'b1;
                n_out               = '0;
                n_out.skipped_count = slfs_pkg::bump_skip(r_skip);
                n_state             = slfs_pkg::ST_IDLE;
            end
            default: begin
                n_state = slfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slfs_pkg::ST_IDLE;
            r_rd_idx  <= '0;
            r_fill    <= '0;
            r_sum_doc <= '0;
            r_sum_off <= '0;
            r_sum_ttf <= '0;
            r_skip    <= slfs_pkg::SKIP_INIT;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_idx  <= n_rd_idx;
            r_fill    <= n_fill;
            r_sum_doc <= n_sum_doc;
            r_sum_off <= n_sum_off;
            r_sum_ttf <= n_sum_ttf;
            r_skip    <= n_skip;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= n_query;
        r_out   <= n_out;
    end

    assign o_valid           = r_valid;
    assign o_found           = r_out.found;
    assign o_doc_id          = r_out.doc_id;
    assign o_prev_doc_id     = r_out.prev_doc_id;
    assign o_prev_offset     = r_out.prev_offset;
    assign o_offset_span     = r_out.offset_span;
    assign o_prev_total_freq = r_out.prev_total_freq;
    assign o_skipped_count   = r_out.skipped_count;

endmodule
